>>> design/sba_pkg.sv
package sba_pkg;

    localparam int BLOCK_COLUMNS = 128;
    localparam int BLOCK_ROWS    = 128;
    localparam int MAX_BLOCKS    = 64;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_ZERO   = 2'd1,
        ST_REJECT = 2'd2,
        ST_LIMIT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_EVAL,
        S_WRITE,
        S_FIN
    } t_state;

endpackage

>>> design/sba_if.sv
interface sba_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] rect_width;
    logic [7:0] rect_height;

    modport source (output valid, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input rect_width, input rect_height, output ready);
    modport monitor (input valid, input rect_width, input rect_height, input ready);
endinterface

interface sba_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] block_index;
    logic [6:0] column_x;
    logic [6:0] row_y;
    logic [6:0] used_blocks;

    modport source (output valid, output status, output block_index, output column_x,
                    output row_y, output used_blocks, input ready);
    modport sink   (input valid, input status, input block_index, input column_x,
                    input row_y, input used_blocks, output ready);
    modport monitor (input valid, input status, input block_index, input column_x,
                     input row_y, input used_blocks, input ready);
endinterface

>>> design/sba_ram.sv
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/skyline_block_allocator_unit.sv
// channel | dir | fields                                   | request moves
// i_req   | in  | rect_width, rect_height                  | one rectangle
// o_res   | out | status, block_index, column_x, row_y,    | one result
//         |     | used_blocks                              |
// Steps: accept, then per block tried a setup, column reads and an eval;
// a window that meets a column no lower than the best so far restarts past it.
// Placement writes w columns (BLOCK_COLUMNS on a block's first placement), then the finish step.
// Reset: one empty block; fill memory is read as zero for unused blocks, no clearing pass.
// Stalls: a held result stalls only the finish step; one request is in work at a time.
module skyline_block_allocator_unit #(
    parameter int BLOCK_COLUMNS = sba_pkg::BLOCK_COLUMNS,
    parameter int BLOCK_ROWS    = sba_pkg::BLOCK_ROWS,
    parameter int MAX_BLOCKS    = sba_pkg::MAX_BLOCKS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sba_req_if.sink   i_req,
    sba_res_if.source o_res
);
    import sba_pkg::*;

    localparam int FW  = $clog2(BLOCK_ROWS + 1);
    localparam int CW  = $clog2(BLOCK_COLUMNS);
    localparam int LW  = ((CW + 1 > 8) ? CW + 1 : 8) + 1;
    localparam int HW  = ((FW > 8) ? FW : 8) + 1;
    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW  = $clog2(MAX_BLOCKS + 1);
    localparam int DEP = MAX_BLOCKS * (2 ** CW);
    localparam int AW  = $clog2(DEP);

    t_state          r_state, n_state;
    logic [7:0]      r_w, n_w, r_h, n_h;
    logic [BW-1:0]   r_blk, n_blk;
    logic [NW-1:0]   r_cnt, n_cnt, r_ucnt, n_ucnt;
    logic [MAX_BLOCKS-1:0] r_used, n_used;
    logic [LW-1:0]   r_i, n_i, r_q, n_q, r_bestx, n_bestx, r_k, n_k, r_kend, n_kend;
    logic [FW-1:0]   r_top, n_top, r_best, n_best;
    t_status         r_st, n_st;
    logic            r_ov, n_ov;
    logic [1:0]      r_o_st, n_o_st;
    logic [5:0]      r_o_blk, n_o_blk;
    logic [6:0]      r_o_x, n_o_x, r_o_y, n_o_y, r_o_u, n_o_u;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [FW-1:0]   wdata, rdata, v, vmax;
    logic [LW-1:0]   col, ni, lim, wx;
    logic [HW-1:0]   nh;
    logic            restart, cur_used;

    sba_ram #(.WIDTH(FW), .DEPTH(DEP)) u_fill (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_st;
    assign o_res.block_index = r_o_blk;
    assign o_res.column_x    = r_o_x;
    assign o_res.row_y       = r_o_y;
    assign o_res.used_blocks = r_o_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= NW'(1);
            r_ucnt  <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ucnt  <= n_ucnt;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
        r_w     <= n_w;
        r_h     <= n_h;
        r_blk   <= n_blk;
        r_i     <= n_i;
        r_q     <= n_q;
        r_bestx <= n_bestx;
        r_k     <= n_k;
        r_kend  <= n_kend;
        r_top   <= n_top;
        r_best  <= n_best;
        r_st    <= n_st;
        r_o_st  <= n_o_st;
        r_o_blk <= n_o_blk;
        r_o_x   <= n_o_x;
        r_o_y   <= n_o_y;
        r_o_u   <= n_o_u;
    end

    always_comb begin
        n_state = r_state;
        n_w = r_w; n_h = r_h; n_blk = r_blk; n_cnt = r_cnt; n_ucnt = r_ucnt;
        n_used = r_used; n_i = r_i; n_q = r_q; n_bestx = r_bestx; n_k = r_k;
        n_kend = r_kend; n_top = r_top; n_best = r_best; n_st = r_st;
        n_ov = r_ov && !o_res.ready;
        n_o_st = r_o_st; n_o_blk = r_o_blk; n_o_x = r_o_x; n_o_y = r_o_y; n_o_u = r_o_u;
        we = 1'b0;
        col = '0;
        restart = 1'b0;
        ni = '0;
        cur_used = r_used[r_blk];
        v = cur_used ? rdata : '0;
        vmax = (v > r_top) ? v : r_top;
        wx = LW'(r_w);
        lim = LW'(BLOCK_COLUMNS) - wx;
        nh = HW'(r_best) + HW'(r_h);
        wdata = (r_k >= r_bestx && r_k < r_bestx + wx) ? FW'(nh) : '0;
        waddr = {r_blk, r_k[CW-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_w = i_req.rect_width;
                    n_h = i_req.rect_height;
                    n_blk = '0;
                    if (i_req.rect_width == 8'd0 || i_req.rect_height == 8'd0) begin
                        n_st = ST_ZERO;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_best = FW'(BLOCK_ROWS);
                n_bestx = '0;
                n_i = '0;
                n_q = '0;
                n_top = '0;
                if (wx >= LW'(BLOCK_COLUMNS)) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (v >= r_best) begin
                    ni = r_i + r_q + LW'(1);
                    restart = 1'b1;
                end else if (r_q == wx - LW'(1)) begin
                    n_best = vmax;
                    n_bestx = r_i;
                    ni = r_i + LW'(1);
                    restart = 1'b1;
                end else begin
                    n_top = vmax;
                    n_q = r_q + LW'(1);
                    col = r_i + r_q + LW'(1);
                end
                if (restart) begin
                    n_i = ni;
                    n_q = '0;
                    n_top = '0;
                    col = ni;
                    if (ni >= lim) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (nh <= HW'(BLOCK_ROWS)) begin
                    if (cur_used) begin
                        n_k = r_bestx;
                        n_kend = r_bestx + wx - LW'(1);
                    end else begin
                        n_k = '0;
                        n_kend = LW'(BLOCK_COLUMNS - 1);
                    end
                    n_state = S_WRITE;
                end else if (NW'(r_blk) + NW'(1) == r_cnt) begin
                    if (!cur_used) begin
                        n_st = ST_REJECT;
                        n_state = S_FIN;
                    end else if (r_cnt >= NW'(MAX_BLOCKS)) begin
                        n_st = ST_LIMIT;
                        n_state = S_FIN;
                    end else begin
                        n_cnt = r_cnt + NW'(1);
                        n_blk = r_blk + BW'(1);
                        n_state = S_SETUP;
                    end
                end else begin
                    n_blk = r_blk + BW'(1);
                    n_state = S_SETUP;
                end
            end
            S_WRITE: begin
                we = 1'b1;
                if (r_k == r_kend) begin
                    if (!cur_used) begin
                        n_ucnt = r_ucnt + NW'(1);
                    end
                    n_used[r_blk] = 1'b1;
                    n_st = ST_PLACED;
                    n_state = S_FIN;
                end else begin
                    n_k = r_k + LW'(1);
                end
            end
            S_FIN: begin
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_o_st = r_st;
                    n_o_u = 7'(r_ucnt);
                    if (r_st == ST_PLACED) begin
                        n_o_blk = 6'(r_blk);
                        n_o_x = 7'(r_bestx);
                        n_o_y = 7'(r_best);
                    end else begin
                        n_o_blk = '0;
                        n_o_x = '0;
                        n_o_y = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        raddr = {r_blk, col[CW-1:0]};
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= NW'(1) && r_cnt <= NW'(MAX_BLOCKS))
        else $error("block count out of range");
    a_ucnt_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= r_cnt)
        else $error("used count above block count");
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_k <= r_kend)
        else $error("write sweep overran");
    a_place_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_best < FW'(BLOCK_ROWS))
        else $error("placement with full best height");
`endif
endmodule
